// ===== hw/rtl/mandelbrot_pixel_escape_assert.svh =====
// Assertion macros shared by the escape-time RTL.
`ifndef MANDELBROT_PIXEL_ESCAPE_ASSERT_SVH
`define MANDELBROT_PIXEL_ESCAPE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define MPE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpe assertion failed");

// Next-cycle implication.
`define MPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpe assertion failed");

`endif

// ===== hw/rtl/mpe_pkg.sv =====
// Package: widths, constants, codes and helpers of the escape-time block.
`timescale 1ns / 1ps
package mpe_pkg;

  localparam int DEF_MAX_SIDE = 4096;
  localparam int IDX_W        = 12;
  localparam int IDX_CMP_W    = 17;
  localparam int Z_W          = 32;
  localparam int STEP_W       = 31;
  localparam int PROD_W       = 64;
  localparam int SUM_W        = 65;
  localparam int CNT_W        = 16;
  localparam int COLOR_W      = 27;
  localparam int FRAC_BITS    = 28;
  localparam int ESC_BIT      = 2 * FRAC_BITS + 2;
  localparam int COLOR_SCALE  = 1808;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int S_DATA_W     = 24;
  localparam int M_DATA_W     = 48;
  localparam int M_USED_W     = COLOR_W + CNT_W + 1;

  localparam logic signed [Z_W-1:0]  RST_ORIGIN_REAL = -32'sd536870912;
  localparam logic signed [Z_W-1:0]  RST_ORIGIN_IMAG = 32'sd536870912;
  localparam logic [STEP_W-1:0]      RST_STEP_REAL   = 31'd1048576;
  localparam logic [STEP_W-1:0]      RST_STEP_IMAG   = 31'd1048576;
  localparam logic [CNT_W-1:0]       RST_MAX_ITER    = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_REAL = 3'd0,
    REG_ORIGIN_IMAG = 3'd1,
    REG_STEP_REAL   = 3'd2,
    REG_STEP_IMAG   = 3'd3,
    REG_MAX_ITER    = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CR,
    S_CI,
    S_CI2,
    S_UPD,
    S_SQR,
    S_SQI,
    S_SQX,
    S_CHK,
    S_FIN
  } state_t;

  // Saturate a wide signed sum to the signed Q4.28 range.
  function automatic logic signed [Z_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-Z_W:0] top;
    top = x[SUM_W-1:Z_W-1];
    if (top == '0 || top == '1) begin
      return x[Z_W-1:0];
    end else if (x[SUM_W-1]) begin
      return {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Z_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== hw/rtl/mpe_mul.sv =====
// Shared signed 32x32 multiplier with registered product.
`timescale 1ns / 1ps
module mpe_mul (
  input  logic                               clk,
  input  logic signed [mpe_pkg::Z_W-1:0]     a,
  input  logic signed [mpe_pkg::Z_W-1:0]     b,
  output logic signed [mpe_pkg::PROD_W-1:0]  prod
);
  import mpe_pkg::*;

  logic signed [PROD_W-1:0] prod_next;

  assign prod_next = PROD_W'(a) * PROD_W'(b);

  always_ff @(posedge clk) begin
    prod <= prod_next;
  end

endmodule

// ===== hw/rtl/mandelbrot_pixel_escape.sv =====
// Top level: per-pixel Mandelbrot escape-time evaluation in Q4.28.
`timescale 1ns / 1ps
// Per pixel: the idle state takes the beat, S_CR, S_CI and S_CI2 set up c, and each iteration
//   runs S_UPD, S_SQR, S_SQI, S_SQX and S_CHK, three of them on the shared 32x32 multiplier;
//   S_FIN then waits until the result register is free.
// The input side is ready only when idle; a finished result waits in the output register.
// Reset (rst, synchronous): sequencer idle, no result held, configuration registers take their defaults.
module mandelbrot_pixel_escape #(
  parameter int MAX_SIDE = mpe_pkg::DEF_MAX_SIDE
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [mpe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mpe_pkg::CFG_DATA_W-1:0]    cfg_data,
  // pixel input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mpe_pkg::S_DATA_W-1:0]      s_axis_tdata,  // row[11:0], col[23:12]
  // result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mpe_pkg::M_DATA_W-1:0]      m_axis_tdata   // color[26:0], iteration_count[42:27],
                                                           // inside_res[43], zero[47:44]
);
  import mpe_pkg::*;

  `include "mandelbrot_pixel_escape_assert.svh"

  localparam logic [IDX_CMP_W-1:0] SIDE_LAST = IDX_CMP_W'(MAX_SIDE - 1);

  // Configuration registers.
  logic signed [Z_W-1:0]    origin_real;
  logic signed [Z_W-1:0]    origin_imag;
  logic [STEP_W-1:0]        step_real;
  logic [STEP_W-1:0]        step_imag;
  logic [CNT_W-1:0]         max_iter;

  // Sequencer and per-pixel working registers.
  state_t                   state, state_next;
  logic [IDX_W-1:0]         row_q, col_q;
  logic [IDX_W-1:0]         row_in, col_in;
  logic signed [Z_W-1:0]    cr, ci, zr, zi;
  logic signed [PROD_W-1:0] rr, ii, ri, diff;
  logic [CNT_W-1:0]         k;

  // Shared multiplier.
  logic signed [Z_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  // Result register.
  logic [COLOR_W-1:0]       out_color;
  logic [CNT_W-1:0]         out_count;
  logic                     out_inside;

  // Combinational helpers.
  logic signed [PROD_W-1:0] diff_sh, ri_sh;
  logic signed [SUM_W-1:0]  zr_sum, zi_sum, cr_sum, ci_sum;
  logic [PROD_W-1:0]        mag;
  logic                     escaped, at_limit, out_free, inside_now;

  // ---------------------------------------------------------------------------
  // Configuration writes; indexes past the last register are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_real <= RST_ORIGIN_REAL;
      origin_imag <= RST_ORIGIN_IMAG;
      step_real   <= RST_STEP_REAL;
      step_imag   <= RST_STEP_IMAG;
      max_iter    <= RST_MAX_ITER;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_REAL: origin_real <= cfg_data[Z_W-1:0];
        REG_ORIGIN_IMAG: origin_imag <= cfg_data[Z_W-1:0];
        REG_STEP_REAL:   step_real   <= cfg_data[STEP_W-1:0];
        REG_STEP_IMAG:   step_imag   <= cfg_data[STEP_W-1:0];
        REG_MAX_ITER:    max_iter    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Clamp the pixel indexes to the last row/column of the plane.
  // ---------------------------------------------------------------------------
  always_comb begin
    row_in = s_axis_tdata[IDX_W-1:0];
    col_in = s_axis_tdata[2*IDX_W-1:IDX_W];
    if (IDX_CMP_W'(row_in) > SIDE_LAST) row_in = SIDE_LAST[IDX_W-1:0];
    if (IDX_CMP_W'(col_in) > SIDE_LAST) col_in = SIDE_LAST[IDX_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Multiplier operand select. The product is registered and shows up in the next cycle:
  //   S_CR  col*step_real  -> used in S_CI  for cr
  //   S_CI  row*step_imag  -> used in S_CI2 for ci
  //   S_SQR zr*zr          -> rr in S_SQI
  //   S_SQI zi*zi          -> ii in S_SQX
  //   S_SQX zr*zi          -> ri in S_CHK
  // ---------------------------------------------------------------------------
  always_comb begin
    case (state)
      S_CR: begin
        mul_a = $signed({{(Z_W-IDX_W){1'b0}}, col_q});
        mul_b = $signed({{(Z_W-STEP_W){1'b0}}, step_real});
      end
      S_CI: begin
        mul_a = $signed({{(Z_W-IDX_W){1'b0}}, row_q});
        mul_b = $signed({{(Z_W-STEP_W){1'b0}}, step_imag});
      end
      S_SQR: begin
        mul_a = zr;
        mul_b = zr;
      end
      S_SQI: begin
        mul_a = zi;
        mul_b = zi;
      end
      S_SQX: begin
        mul_a = zr;
        mul_b = zi;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mpe_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // ---------------------------------------------------------------------------
  // Arithmetic around the multiplier.
  // c: origin_real plus col*step_real, origin_imag minus row*step_imag, saturated. z update:
  // arithmetic shifts floor toward minus infinity, then add c and saturate. |z|^2 of the new z
  // is the sum of the next iteration's squares, so the escape test reuses rr and ii.
  // ---------------------------------------------------------------------------
  assign cr_sum  = {{(SUM_W-Z_W){origin_real[Z_W-1]}}, origin_real} + {prod[PROD_W-1], prod};
  assign ci_sum  = {{(SUM_W-Z_W){origin_imag[Z_W-1]}}, origin_imag} - {prod[PROD_W-1], prod};

  assign diff_sh = diff >>> FRAC_BITS;
  assign ri_sh   = ri >>> (FRAC_BITS - 1);
  assign zr_sum  = {diff_sh[PROD_W-1], diff_sh} + {{(SUM_W-Z_W){cr[Z_W-1]}}, cr};
  assign zi_sum  = {ri_sh[PROD_W-1], ri_sh} + {{(SUM_W-Z_W){ci[Z_W-1]}}, ci};

  // Both squares are non-negative and at most 2^62, so the unsigned sum cannot wrap.
  assign mag        = $unsigned(rr) + $unsigned(ii);
  assign escaped    = (mag[PROD_W-1:ESC_BIT] != '0);
  assign at_limit   = (k >= max_iter);
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign inside_now = at_limit;

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = S_CR;
      end
      S_CR:  state_next = S_CI;
      S_CI:  state_next = S_CI2;
      S_CI2: state_next = S_UPD;
      S_UPD: state_next = S_SQR;
      S_SQR: state_next = S_SQI;
      S_SQI: state_next = S_SQX;
      S_SQX: state_next = S_CHK;
      S_CHK: begin
        // A step that lands on the limit ends the run even if it escaped.
        if (escaped || at_limit) begin
          state_next = S_FIN;
        end else begin
          state_next = S_UPD;
        end
      end
      S_FIN: begin
        // Hold the finished pixel until the result register frees up.
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Working registers: payload only, no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        row_q <= row_in;
        col_q <= col_in;
      end
      S_CI: cr <= sat32(cr_sum);
      S_CI2: begin
        ci   <= sat32(ci_sum);
        // z starts at zero, so the first update yields z = c.
        diff <= '0;
        ri   <= '0;
        k    <= '0;
      end
      S_UPD: begin
        zr <= sat32(zr_sum);
        zi <= sat32(zi_sum);
        k  <= k + CNT_W'(1);
      end
      S_SQI: rr <= prod;
      S_SQX: ii <= prod;
      S_CHK: begin
        ri   <= prod;
        diff <= rr - ii;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_count  <= k;
      out_inside <= inside_now;
      out_color  <= inside_now ? '0 : COLOR_W'(k) * COLOR_W'(COLOR_SCALE);
    end
  end

  assign m_axis_tdata = {{(M_DATA_W-M_USED_W){1'b0}}, out_inside, out_count, out_color};

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  // An accepted pixel starts the c setup on the very next cycle.
  `MPE_ASSERT_NEXT(a_accept_starts, s_axis_tvalid && s_axis_tready, state == S_CR)
  // Another update runs only on the first step or while under the limit.
  `MPE_ASSERT_NOW(a_upd_under_limit, state == S_UPD, k == '0 || k < max_iter)
  // A new result appears only out of the finish step.
  `MPE_ASSERT_NOW(a_result_from_fin, $rose(m_axis_tvalid), $past(state == S_FIN))
  // Inside points always carry a zero color.
  `MPE_ASSERT_NOW(a_inside_black, m_axis_tvalid && out_inside, out_color == '0)

endmodule

// ===== tb/tb_mandelbrot_pixel_escape.sv =====
// Self-checking testbench for the per-pixel Mandelbrot escape-time block.
`timescale 1ns / 1ps
module tb_mandelbrot_pixel_escape;
  import mpe_pkg::*;

  // Plan entries: a pixel beat, a register write, a hold until the block is
  // quiet, or a change of the idling pattern on both sides.
  typedef enum logic [1:0] {
    STIM_PIXEL,
    STIM_REG_WRITE,
    STIM_WAIT_IDLE,
    STIM_PACING
  } stim_kind_t;

  typedef struct packed {
    stim_kind_t       kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    cfg_reg_t         sel;
    logic [31:0]      value;
    logic [6:0]       src_idle;
    logic [6:0]       snk_idle;
  } plan_entry_t;

  // Result fields in the order they sit in m_axis_tdata, lowest last.
  typedef struct packed {
    logic               in_set;
    logic [CNT_W-1:0]   count;
    logic [COLOR_W-1:0] color;
  } escape_res_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    escape_res_t      res;
  } pixel_due_t;

  localparam longint     Q_MAX   = 64'sd2147483647;
  localparam longint     Q_MIN   = -64'sd2147483648;
  localparam logic [64:0] ESC_MAG = 65'd1 << ESC_BIT;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;  // row[11:0], col[23:12]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;        // color[26:0], iteration_count[42:27],
                                              // inside_res[43], zero[47:44]

  // Shadow copy of the configuration, used by the escape predictor.
  logic signed [Z_W-1:0] pm_origin_re = RST_ORIGIN_REAL;
  logic signed [Z_W-1:0] pm_origin_im = RST_ORIGIN_IMAG;
  logic [STEP_W-1:0]     pm_step_re   = RST_STEP_REAL;
  logic [STEP_W-1:0]     pm_step_im   = RST_STEP_IMAG;
  logic [CNT_W-1:0]      pm_limit     = RST_MAX_ITER;

  plan_entry_t pixel_plan[$];
  pixel_due_t  due_results[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_errors     = 0;
  logic [IDX_W-1:0] held_row = '0;
  logic [IDX_W-1:0] held_col = '0;

  mandelbrot_pixel_escape DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Escape predictor
  // ---------------------------------------------------------------------

  // Clip a wide value to the signed Q4.28 range.
  function automatic longint sat_q428(input longint x);
    if (x > Q_MAX) begin
      return Q_MAX;
    end else if (x < Q_MIN) begin
      return Q_MIN;
    end
    return x;
  endfunction

  // Map the pixel to c, iterate z = z^2 + c from zero, and build the
  // result beat that the block owes for it under the current settings.
  function automatic escape_res_t escape_eval(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
    longint ore, oim, sr, si, rl, cl;
    longint cre, cim, zr, zi, rr, ii, ri;
    logic [64:0] mag;
    int unsigned k;
    logic done;
    escape_res_t res;
    ore = pm_origin_re;
    oim = pm_origin_im;
    sr  = pm_step_re;
    si  = pm_step_im;
    rl  = r;
    cl  = c;
    cre = sat_q428(ore + cl * sr);
    cim = sat_q428(oim - rl * si);
    zr = 0;
    zi = 0;
    k = 0;
    done = 1'b0;
    while (!done) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      // Arithmetic shifts floor toward minus infinity; zr*zi is doubled by
      // shifting one bit less.
      zr = sat_q428(((rr - ii) >>> FRAC_BITS) + cre);
      zi = sat_q428((ri >>> (FRAC_BITS - 1)) + cim);
      rr = zr * zr;
      ii = zi * zi;
      mag = {1'b0, rr} + {1'b0, ii};
      k++;
      done = (mag >= ESC_MAG) || (k >= pm_limit);
    end
    res.in_set = (k >= pm_limit);
    res.count  = k[CNT_W-1:0];
    res.color  = res.in_set ? '0 : COLOR_W'(k * COLOR_SCALE);
    return res;
  endfunction

  task automatic load_model_reg(input cfg_reg_t sel, input logic [31:0] v);
    case (sel)
      REG_ORIGIN_REAL: pm_origin_re = v;
      REG_ORIGIN_IMAG: pm_origin_im = v;
      REG_STEP_REAL:   pm_step_re   = v[STEP_W-1:0];
      REG_STEP_IMAG:   pm_step_im   = v[STEP_W-1:0];
      REG_MAX_ITER:    pm_limit     = v[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Plan builders
  // ---------------------------------------------------------------------

  task automatic add_pixel(input int unsigned r, input int unsigned c);
    plan_entry_t e;
    e = '0;
    e.kind = STIM_PIXEL;
    e.row  = r[IDX_W-1:0];
    e.col  = c[IDX_W-1:0];
    pixel_plan.push_back(e);
  endtask

  task automatic add_reg(input cfg_reg_t sel, input logic [31:0] v);
    plan_entry_t e;
    e = '0;
    e.kind  = STIM_REG_WRITE;
    e.sel   = sel;
    e.value = v;
    pixel_plan.push_back(e);
  endtask

  task automatic add_wait_idle();
    plan_entry_t e;
    e = '0;
    e.kind = STIM_WAIT_IDLE;
    pixel_plan.push_back(e);
  endtask

  task automatic add_pacing(input int unsigned src, input int unsigned snk);
    plan_entry_t e;
    e = '0;
    e.kind     = STIM_PACING;
    e.src_idle = src[6:0];
    e.snk_idle = snk[6:0];
    pixel_plan.push_back(e);
  endtask

  // Print one line per bad field and count it.
  task automatic report_mismatch(input string what, input pixel_due_t want,
                                 input int unsigned got_v, input int unsigned want_v);
    $display("MISMATCH %s pixel row %0d col %0d: got %0d, want %0d at %0t ns",
             what, want.row, want.col, got_v, want_v, $time);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus plan
  // ---------------------------------------------------------------------
  initial begin : plan_fill
    int unsigned p, i, lim;
    int ore, oim;
    add_pacing(12, 67);

    // Power-on settings: origin (-2, 2), step 1/256, limit 256.
    add_pixel(0, 0);          // c = -2+2i, escapes on the first step
    add_pixel(512, 512);      // c = 0, never escapes
    add_pixel(4095, 4095);
    add_pixel(0, 4095);
    add_pixel(4095, 0);
    add_pixel(512, 0);        // c = -2, lands exactly on |z|^2 = 4
    add_pixel(512, 576);      // c = 0.25, creeps toward the cusp
    add_pixel(512, 580);      // just past the cusp, slow escape

    // Limit of zero: a single step, always counted as inside.
    add_reg(REG_MAX_ITER, 32'd0);
    add_pixel(512, 512);
    add_pixel(0, 0);

    // Escape on the last allowed step still counts as inside.
    add_reg(REG_MAX_ITER, 32'd1);
    add_pixel(0, 0);
    add_pixel(512, 600);
    add_reg(REG_MAX_ITER, 32'd2);
    add_pixel(512, 580);
    add_pixel(300, 300);

    // Extreme registers: drive c into saturation on both sides.
    add_reg(REG_ORIGIN_REAL, 32'h7FFF_FFFF);
    add_reg(REG_ORIGIN_IMAG, 32'h8000_0000);
    add_reg(REG_STEP_REAL,   32'h7FFF_FFFF);
    add_reg(REG_STEP_IMAG,   32'hFFFF_FFFF);
    add_reg(REG_MAX_ITER,    32'h0000_FFFF);
    add_pixel(4095, 4095);
    add_pixel(0, 0);
    add_reg(REG_ORIGIN_REAL, 32'h8000_0000);
    add_reg(REG_ORIGIN_IMAG, 32'h7FFF_FFFF);
    add_reg(REG_STEP_REAL,   32'h0);
    add_reg(REG_STEP_IMAG,   32'h0);
    add_pixel(4095, 4095);

    // Zero plane at the largest limit: the full count, once.
    add_reg(REG_ORIGIN_REAL, 32'h0);
    add_reg(REG_ORIGIN_IMAG, 32'h0);
    add_pixel(1234, 2345);

    // Random windows over the set, plus one noise phase with arbitrary
    // registers. Keep limits small so inside points stay cheap.
    for (p = 0; p < 8; p++) begin
      if (p == 3) add_pacing(67, 12);
      if (p == 6) add_pacing(0, 0);
      if (p == 0) begin
        lim = 100;
      end else if (p == 2) begin
        lim = 1;
      end else begin
        lim = $urandom_range(40, 2);
      end
      if (p == 5) begin
        add_reg(REG_ORIGIN_REAL, $urandom);
        add_reg(REG_ORIGIN_IMAG, $urandom);
        add_reg(REG_STEP_REAL,   $urandom);
        add_reg(REG_STEP_IMAG,   $urandom);
      end else begin
        ore = -536870912 - int'($urandom_range(134217728));
        oim = 268435456 + int'($urandom_range(268435456));
        add_reg(REG_ORIGIN_REAL, ore);
        add_reg(REG_ORIGIN_IMAG, oim);
        add_reg(REG_STEP_REAL, ($urandom_range(1) << 31) | $urandom_range(196608, 65536));
        add_reg(REG_STEP_IMAG, ($urandom_range(1) << 31) | $urandom_range(196608, 65536));
      end
      add_reg(REG_MAX_ITER, ($urandom_range(65535) << 16) | lim);
      for (i = 0; i < 190; i++) begin
        // Hold the sender once until the block has nothing left in flight.
        if (p == 4 && i == 95) add_wait_idle();
        add_pixel($urandom_range(4095), $urandom_range(4095));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: feed pixels and register writes from the plan
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : pixel_driver
    plan_entry_t e;
    pixel_due_t  d;
    logic nxt_valid, nxt_we;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_we        <= 1'b0;
      quiet_cycles  = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_we    = 1'b0;
      // Predict at the edge the beat is taken, with the settings in force.
      if (s_axis_tvalid && s_axis_tready) begin
        d.row = held_row;
        d.col = held_col;
        d.res = escape_eval(held_row, held_col);
        due_results.push_back(d);
        nxt_valid = 1'b0;
      end
      if (due_results.size() == 0 && !nxt_valid) quiet_cycles++;
      else quiet_cycles = 0;

      if (!nxt_valid && pixel_plan.size() != 0) begin
        e = pixel_plan[0];
        case (e.kind)
          STIM_PIXEL: begin
            if ($urandom_range(99) >= src_idle_pct) begin
              e = pixel_plan.pop_front();
              held_row = e.row;
              held_col = e.col;
              s_axis_tdata <= {e.col, e.row};
              nxt_valid = 1'b1;
            end
          end
          STIM_REG_WRITE: begin
            // Write only once the block has been quiet, with nothing in flight.
            if (quiet_cycles >= 4) begin
              e = pixel_plan.pop_front();
              cfg_index <= e.sel;
              cfg_data  <= e.value;
              nxt_we = 1'b1;
              load_model_reg(e.sel, e.value);
            end
          end
          STIM_WAIT_IDLE: begin
            if (quiet_cycles >= 4) e = pixel_plan.pop_front();
          end
          default: begin
            e = pixel_plan.pop_front();
            src_idle_pct = e.src_idle;
            snk_idle_pct = e.snk_idle;
          end
        endcase
      end
      s_axis_tvalid <= nxt_valid;
      cfg_we        <= nxt_we;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: stall the result side at random and check every beat
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    escape_res_t got;
    pixel_due_t  want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[M_USED_W-1:0];
        if (due_results.size() == 0) begin
          want = '0;
          report_mismatch("unexpected result beat, count", want, got.count, 0);
        end else begin
          want = due_results.pop_front();
          if (got.color !== want.res.color)
            report_mismatch("color", want, got.color, want.res.color);
          if (got.count !== want.res.count)
            report_mismatch("iteration_count", want, got.count, want.res.count);
          if (got.in_set !== want.res.in_set)
            report_mismatch("inside_res", want, got.in_set, want.res.in_set);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Reset, drain and verdict
  // ---------------------------------------------------------------------
  initial begin : run_ctrl
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Sample between edges so every update of the edge has landed.
    while (pixel_plan.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk);
    // Give a stray extra beat time to show up.
    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #200_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
